### hw/rtl/tpq_pkg.sv
// shared types, constants and the entry order for the task priority queue
`default_nettype none
package tpq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W       = 7;
  localparam int BACKLOG_W   = 7;
  localparam logic [BACKLOG_W-1:0] BACKLOG_RESET = 7'd64;

  // register byte addresses
  localparam logic [2:0] ADDR_MAX_BACKLOG = 3'd0;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_REQUEUE = 2'd1,
    OP_POP     = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] id;
    logic [3:0]  level;
    logic [31:0] score;
  } entry_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] task_id;
    logic [3:0]  level;
    logic [31:0] score;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      task_id;
    logic [3:0]       level;
    logic [31:0]      score;
    logic             fallback;
    logic [OCC_W-1:0] occupancy;
  } res_t;

  // true when a must leave strictly before b
  function automatic logic ranks_before(entry_t a, entry_t b);
    logic na;
    logic nb;
    na = a.score[31];
    nb = b.score[31];
    if (a.level != b.level) return a.level < b.level;
    if (na && nb) return a.id < b.id;
    if (na != nb) return na;
    if (a.score != b.score) return a.score > b.score;
    return a.id < b.id;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/tpq_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none
module tpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### hw/rtl/tpq_ctrl.sv
// sequencer: store, best-entry scan and compaction over the entry ram
`default_nettype none
module tpq_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           req_valid_i,
  output logic                                req_ready_o,
  input  wire tpq_pkg::req_t                  req_i,
  input  wire logic [tpq_pkg::BACKLOG_W-1:0]  max_backlog_i,
  output logic                                res_valid_o,
  input  wire logic                           res_ready_i,
  output tpq_pkg::res_t                       res_o
);

  localparam int CW  = tpq_pkg::CNT_W;
  localparam int AW  = tpq_pkg::ADDR_W;
  localparam int CMPW = CW + tpq_pkg::BACKLOG_W;
  localparam logic [CW-1:0] FULL = CW'(tpq_pkg::QUEUE_DEPTH);

  tpq_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [31:0]     next_id_q, next_id_d;
  logic [CW-1:0]   rd_cnt_q, rd_cnt_d;
  logic            pend_q, pend_d;
  logic [CW-1:0]   pidx_q, pidx_d;
  tpq_pkg::entry_t best_q, best_d;
  logic [CW-1:0]   best_idx_q, best_idx_d;
  tpq_pkg::res_t   res_q, res_d;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  tpq_pkg::entry_t ram_wdata;
  logic [$bits(tpq_pkg::entry_t)-1:0] ram_rdata;
  tpq_pkg::entry_t cand;
  logic            take;
  logic [CW-1:0]   left;

  assign cand = tpq_pkg::entry_t'(ram_rdata);
  assign left = cnt_q - CW'(1);

  tpq_ram #(
    .WIDTH($bits(tpq_pkg::entry_t)),
    .DEPTH(tpq_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    next_id_d  = next_id_q;
    rd_cnt_d   = rd_cnt_q;
    pend_d     = 1'b0;
    pidx_d     = pidx_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = cnt_q[AW-1:0];
    ram_raddr  = rd_cnt_q[AW-1:0];
    ram_wdata  = '{id: next_id_q, level: req_i.level, score: req_i.score};
    take       = 1'b0;
    req_ready_o = (state_q == tpq_pkg::S_IDLE);
    res_valid_o = (state_q == tpq_pkg::S_DONE);

    case (state_q)
      tpq_pkg::S_IDLE: begin
        if (req_valid_i) begin
          res_d = '0;
          res_d.occupancy = tpq_pkg::OCC_W'(cnt_q);
          state_d = tpq_pkg::S_DONE;
          case (tpq_pkg::opcode_e'(req_i.opcode))
            tpq_pkg::OP_ADD: begin
              if (cnt_q < FULL) begin
                ram_we = 1'b1;
                cnt_d = cnt_q + CW'(1);
                next_id_d = next_id_q + 32'd1;
                res_d.task_id = next_id_q;
                res_d.occupancy = tpq_pkg::OCC_W'(cnt_q + CW'(1));
              end else begin
                res_d.status = tpq_pkg::STAT_FULL;
              end
            end
            tpq_pkg::OP_REQUEUE: begin
              res_d.task_id = req_i.task_id;
              ram_wdata.id = req_i.task_id;
              if (cnt_q < FULL) begin
                ram_we = 1'b1;
                cnt_d = cnt_q + CW'(1);
                res_d.occupancy = tpq_pkg::OCC_W'(cnt_q + CW'(1));
              end else begin
                res_d.status = tpq_pkg::STAT_FULL;
              end
            end
            tpq_pkg::OP_POP: begin
              if (cnt_q == '0) begin
                res_d.status = tpq_pkg::STAT_EMPTY;
              end else begin
                rd_cnt_d = '0;
                state_d = tpq_pkg::S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      tpq_pkg::S_SCAN: begin
        if (rd_cnt_q < cnt_q) begin
          ram_re = 1'b1;
          rd_cnt_d = rd_cnt_q + CW'(1);
          pend_d = 1'b1;
          pidx_d = rd_cnt_q;
        end
        if (pend_q) begin
          take = (pidx_q == '0) || tpq_pkg::ranks_before(cand, best_q);
          if (take) begin
            best_d = cand;
            best_idx_d = pidx_q;
          end
          if (pidx_q == left) begin
            rd_cnt_d = (take ? pidx_q : best_idx_q) + CW'(1);
            pend_d = 1'b0;
            state_d = tpq_pkg::S_SHIFT;
            res_d.status = tpq_pkg::STAT_OK;
            res_d.task_id = best_d.id;
            res_d.level = best_d.level;
            res_d.score = best_d.score;
            res_d.fallback = (CMPW'(left) > CMPW'(max_backlog_i));
            res_d.occupancy = tpq_pkg::OCC_W'(left);
          end
        end
      end
      tpq_pkg::S_SHIFT: begin
        // each later entry moves down one slot, written in the cycle after its read
        if (rd_cnt_q < cnt_q) begin
          ram_re = 1'b1;
          rd_cnt_d = rd_cnt_q + CW'(1);
          pend_d = 1'b1;
          pidx_d = rd_cnt_q;
        end
        if (pend_q) begin
          ram_we = 1'b1;
          ram_waddr = AW'(pidx_q - CW'(1));
          ram_wdata = cand;
        end
        if (!(rd_cnt_q < cnt_q) && !pend_q) begin
          cnt_d = left;
          state_d = tpq_pkg::S_DONE;
        end
      end
      tpq_pkg::S_DONE: begin
        if (res_ready_i) state_d = tpq_pkg::S_IDLE;
      end
      default: state_d = tpq_pkg::S_IDLE;
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tpq_pkg::S_IDLE;
      cnt_q     <= '0;
      next_id_q <= '0;
      rd_cnt_q  <= '0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      next_id_q <= next_id_d;
      rd_cnt_q  <= rd_cnt_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q     <= pidx_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    res_q      <= res_d;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL) else $error("entry count beyond depth");
  a_shift_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tpq_pkg::S_SHIFT |-> cnt_q != '0) else $error("compaction on empty queue");
  a_scan_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tpq_pkg::S_SCAN && pend_q) |-> pidx_q < cnt_q)
    else $error("scan index past fill");
  a_store_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q == tpq_pkg::S_IDLE) |=> state_q == tpq_pkg::S_DONE)
    else $error("store did not complete");
`endif

endmodule
`default_nettype wire

### hw/rtl/task_priority_queue.sv
// top level of the task priority queue: stream ports, register port, result register
`default_nettype none
// bounded priority queue of up to 64 tasks held in one entry ram in storage
// order. an add or requeue writes the entry at the fill position. a pop scans
// every held entry through the ram read port, one per cycle, keeping the best,
// then closes the gap by moving each later entry down one slot (one read and
// one write per cycle). one item is worked on at a time; the next item is
// accepted as soon as the result sits in the output register. an empty pop
// or a full store returns a status and changes nothing. max_backlog lies at
// address 0 and sets the fallback threshold for pops.
module task_priority_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // opcode[1:0], task_id[33:2], level[37:34], score[69:38], zero fill
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[1:0], out_task_id[33:2], out_level[37:34], out_score[69:38],
  // fallback[70], occupancy[77:71], zero fill
  output logic      [79:0] m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [tpq_pkg::BACKLOG_W-1:0] max_backlog_q;
  tpq_pkg::req_t req;
  tpq_pkg::res_t res;
  logic          res_valid, res_ready;
  logic          out_valid_q;
  tpq_pkg::res_t out_q;

  // register port, always ready
  assign pready = 1'b1;
  assign prdata = (paddr == tpq_pkg::ADDR_MAX_BACKLOG) ? {25'd0, max_backlog_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_backlog_q <= tpq_pkg::BACKLOG_RESET;
    end else if (psel && penable && pwrite && paddr == tpq_pkg::ADDR_MAX_BACKLOG) begin
      max_backlog_q <= pwdata[tpq_pkg::BACKLOG_W-1:0];
    end
  end

  // unpack the input item
  assign req.opcode  = s_axis_tdata[1:0];
  assign req.task_id = s_axis_tdata[33:2];
  assign req.level   = s_axis_tdata[37:34];
  assign req.score   = s_axis_tdata[69:38];

  tpq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_o   (s_axis_tready),
    .req_i         (req),
    .max_backlog_i (max_backlog_q),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // output register parts the sequencer from the downstream stall
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.occupancy, out_q.fallback, out_q.score,
                          out_q.level, out_q.task_id, out_q.status};

endmodule
`default_nettype wire

### tb/task_priority_queue_checker.sv
// checker for the task priority queue: predicts each result and compares it field by field
module task_priority_queue_checker
  import tpq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [79:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] id;
    logic [3:0]  level;
    logic [31:0] score;
    logic        fallback;
    logic [6:0]  occupancy;
  } outcome_t;

  logic [31:0] held_id[$];
  logic [3:0]  held_level[$];
  logic [31:0] held_score[$];
  logic [31:0] id_counter;
  logic [6:0]  backlog_limit;
  outcome_t    awaited[$];
  int          errors;

  assign errors_o  = errors;
  assign pending_o = awaited.size();

  // custom order: level, then negative-by-id, negative first, higher score, lower id
  function automatic bit leaves_first(int a, int b);
    bit na, nb;
    na = held_score[a][31];
    nb = held_score[b][31];
    if (held_level[a] != held_level[b]) return held_level[a] < held_level[b];
    if (na && nb) return held_id[a] < held_id[b];
    if (na != nb) return na;
    if (held_score[a] != held_score[b]) return held_score[a] > held_score[b];
    return held_id[a] < held_id[b];
  endfunction

  function automatic outcome_t apply_task_op(logic [71:0] d);
    outcome_t r;
    logic [1:0] op;
    int best;
    op = d[1:0];
    r = '{STAT_OK, 32'd0, 4'd0, 32'd0, 1'b0, 7'd0};
    if (op == OP_ADD || op == OP_REQUEUE) begin
      if (op == OP_REQUEUE) r.id = d[33:2];
      if (held_id.size() >= QUEUE_DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        if (op == OP_ADD) begin
          r.id = id_counter;
          id_counter = id_counter + 1;
        end
        held_id.push_back(r.id);
        held_level.push_back(d[37:34]);
        held_score.push_back(d[69:38]);
      end
    end else if (op == OP_POP) begin
      if (held_id.size() == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        best = 0;
        for (int i = 1; i < held_id.size(); i++)
          if (leaves_first(i, best)) best = i;
        r.id = held_id[best];
        r.level = held_level[best];
        r.score = held_score[best];
        held_id.delete(best);
        held_level.delete(best);
        held_score.delete(best);
        r.fallback = held_id.size() > backlog_limit;
      end
    end
    r.occupancy = 7'(held_id.size());
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t w;
    if (!rst_ni) begin
      held_id.delete();
      held_level.delete();
      held_score.delete();
      awaited.delete();
      id_counter = 0;
      backlog_limit = BACKLOG_RESET;
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_MAX_BACKLOG)
        backlog_limit = pwdata[6:0];
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited.size() == 0) begin
          report("unexpected item", m_axis_tdata[33:2], 32'd0);
        end else begin
          w = awaited.pop_front();
          if (m_axis_tdata[1:0] != w.status) report("status", m_axis_tdata[1:0], w.status);
          if (m_axis_tdata[33:2] != w.id) report("task_id", m_axis_tdata[33:2], w.id);
          if (m_axis_tdata[37:34] != w.level) report("level", m_axis_tdata[37:34], w.level);
          if (m_axis_tdata[69:38] != w.score) report("score", m_axis_tdata[69:38], w.score);
          if (m_axis_tdata[70] != w.fallback)
            report("fallback", m_axis_tdata[70], w.fallback);
          if (m_axis_tdata[77:71] != w.occupancy)
            report("occupancy", m_axis_tdata[77:71], w.occupancy);
        end
      end
      if (s_axis_tvalid && s_axis_tready) awaited.push_back(apply_task_op(s_axis_tdata));
    end
  end
endmodule

### tb/task_priority_queue_tb.sv
// testbench top for the task priority queue: stimulus, register writes and verdict
module task_priority_queue_tb;
  import tpq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // opcode, task_id, level, score from bit 0 up
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // status, out_task_id, out_level, out_score, fallback, occupancy from bit 0 up
  logic [79:0] m_axis_tdata;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors, pending;
  int          cycles = 0;
  bit          calm = 1'b0;   // no idling in the closing stretch

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task_priority_queue DUT (.*);

  task_priority_queue_checker checker_i (.*, .errors_o(errors), .pending_o(pending));

  // watchdog: ends the run with an error verdict if the test hangs
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 800000) begin
      $display("task_priority_queue_tb: errors");
      $finish;
    end
  end

  // receiver: random stall bursts, none in the closing stretch
  initial begin
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send(logic [1:0] op, logic [31:0] id, logic [3:0] lvl, logic [31:0] sc);
    if (!calm && $urandom_range(0, 6) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    s_axis_tdata  <= {2'b00, sc, lvl, id, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (140) @(negedge clk_i);   // quiet gap before the next phase
  endtask

  task automatic write_backlog(logic [31:0] v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_MAX_BACKLOG; pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // random score with a bias towards sign boundaries and ties
  function automatic logic [31:0] any_score();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(signed'($urandom_range(0, 6)) - 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_op(int pop_weight);
    int k;
    k = $urandom_range(0, 99);
    if (k < pop_weight) send(OP_POP, $urandom, $urandom, $urandom);
    else if (k < pop_weight + 15) send(OP_REQUEUE, $urandom, $urandom, any_score());
    else send(OP_ADD, $urandom, $urandom_range(0, 15) & ($urandom_range(0, 1) ? 4'h3 : 4'hf),
              any_score());
  endtask

  initial begin
    int bl[5] = '{0, 64, 127, 5, 20};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty pop, sign cases, equal ranks, extremes, unused opcode
    send(OP_POP, 32'hffff_ffff, 4'hf, 32'hffff_ffff);
    send(OP_ADD, 32'hffff_ffff, 4'd0, 32'h0000_0000);
    send(OP_ADD, 32'd0, 4'd0, 32'hffff_0000);
    send(OP_REQUEUE, 32'hffff_ffff, 4'd0, 32'h8000_0000);
    send(OP_REQUEUE, 32'd0, 4'd0, 32'h7fff_ffff);
    send(OP_REQUEUE, 32'd7, 4'hf, 32'h0001_0000);
    send(OP_REQUEUE, 32'd3, 4'hf, 32'h0001_0000);
    send(OP_REQUEUE, 32'd3, 4'hf, 32'h0001_0000);
    send(2'd3, 32'hffff_ffff, 4'hf, 32'hffff_ffff);
    repeat (9) send(OP_POP, '0, '0, '0);
    drain();

    // fill past full, check drop on add and on requeue, then empty out
    write_backlog(0);
    repeat (65) send(OP_ADD, $urandom, $urandom, any_score());
    send(OP_REQUEUE, 32'h1234_5678, 4'd1, 32'd1);
    repeat (66) send(OP_POP, '0, '0, '0);
    drain();

    // random phases over several backlog limits
    foreach (bl[p]) begin
      write_backlog(bl[p]);
      for (int i = 0; i < 220; i++) random_op(p == 3 ? 30 : 42);
      drain();
    end

    // closing stretch with no idling on either side
    calm = 1'b1;
    write_backlog(64);
    repeat (60) random_op(45);
    drain();

    if (errors == 0) begin
      $display("task_priority_queue_tb: clean");
    end else begin
      $display("task_priority_queue_tb: errors");
    end
    $finish;
  end
endmodule

### files.f
hw/rtl/tpq_pkg.sv
hw/rtl/tpq_ram.sv
hw/rtl/tpq_ctrl.sv
hw/rtl/task_priority_queue.sv
tb/task_priority_queue_checker.sv
tb/task_priority_queue_tb.sv
